// File: sv/weighted_random_entry_picker_macros.svh
// Assertion macros shared by the picker RTL.
// Needs a clock named clock and a reset named reset in the using module.
`ifndef WEIGHTED_RANDOM_ENTRY_PICKER_MACROS_SVH
`define WEIGHTED_RANDOM_ENTRY_PICKER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define WREP_ASSERT_NOW(lbl, ant, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ant) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define WREP_ASSERT_NEXT(lbl, ant, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ant) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/wrep_pkg.sv
// Package for the weighted random entry picker: item types, codes, defaults.
// No dependencies.
`timescale 1ns / 1ps

package wrep_pkg;

   localparam int DEF_ENTRIES     = 64;
   localparam int DEF_WEIGHT_BITS = 16;

   localparam int KIND_W          = 3;
   localparam int FIELD_W         = 16;   // weight and tag fields
   localparam int TOTAL_W         = 22;   // random value and totals
   localparam int PICK_COUNT_W    = 7;
   localparam int STATUS_W        = 2;
   localparam int ENTRY_INDEX_W   = 6;

   typedef enum logic [KIND_W-1:0] {
      KIND_CLEAR  = 3'd0,
      KIND_APPEND = 3'd1,
      KIND_PICK   = 3'd2,
      KIND_SET    = 3'd3,
      KIND_DRAW   = 3'd4
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EMPTY     = 2'd1,
      STATUS_EXHAUSTED = 2'd2,
      STATUS_NO_DRAW   = 2'd3
   } status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_WALK = 1'b1
   } state_type;

   typedef enum logic [1:0] {
      MODE_PICK = 2'd0,   // weighted walk, marks ignored
      MODE_DRAW = 2'd1,   // weighted walk over unmarked entries
      MODE_ALL  = 2'd2    // stream every entry in order
   } mode_type;

   typedef struct packed {
      logic [KIND_W-1:0]       kind;
      logic [FIELD_W-1:0]      weight;
      logic [FIELD_W-1:0]      tag;
      logic [TOTAL_W-1:0]      random_value;
      logic [PICK_COUNT_W-1:0] pick_count;
   } req_type;

   typedef struct packed {
      status_type               status;
      logic [ENTRY_INDEX_W-1:0] entry_index;
      logic [FIELD_W-1:0]       entry_tag;
      logic                     last;
   } rsp_type;

endpackage

// File: sv/wrep_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module wrep_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 64,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// File: sv/weighted_random_entry_picker.sv
// Weighted random entry picker: entry table in RAM, walk sequencer, result register.
// Depends on wrep_pkg, wrep_ram and weighted_random_entry_picker_macros.svh.
//
//   channel  ports                    handshake
//   -------  -----------------------  ---------------------------------------
//   request  start, busy, req_data    taken at a clock edge with start & !busy
//   result   rsp_valid, rsp_data      one-cycle strobe, always taken
//
// Clear and append finish without a walk. Pick, draw and a full-set draw walk the
// entry RAM one entry per cycle through its single read port. A result is
// registered in the cycle after the entry that produced it. Reset is synchronous,
// active high, and empties the table at once (no clearing pass). The receiver
// never stalls.
`timescale 1ns / 1ps

module weighted_random_entry_picker #(
   parameter int ENTRIES     = wrep_pkg::DEF_ENTRIES,
   parameter int WEIGHT_BITS = wrep_pkg::DEF_WEIGHT_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  wrep_pkg::req_type req_data,
   output logic             rsp_valid,
   output wrep_pkg::rsp_type rsp_data
);

   import wrep_pkg::*;
   `include "weighted_random_entry_picker_macros.svh"

   // The weight field is 16 bits; storage keeps at most WEIGHT_BITS of it.
   localparam int WS     = (WEIGHT_BITS < FIELD_W) ? WEIGHT_BITS : FIELD_W;
   localparam int IW     = $clog2(ENTRIES);
   localparam int CW     = $clog2(ENTRIES + 1);
   localparam int CMP_W  = (CW > PICK_COUNT_W) ? CW : PICK_COUNT_W;
   localparam int RAM_W  = WS + FIELD_W;

   // Control and table state.
   state_type              state_ff, state_in;
   mode_type               mode_ff, mode_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [TOTAL_W-1:0]     total_ff, total_in;
   logic [TOTAL_W-1:0]     remain_ff, remain_in;
   logic [PICK_COUNT_W-1:0] draws_ff, draws_in;
   logic [ENTRIES-1:0]     marks_ff, marks_in;

   // Walk pipeline: read issue counter and the entry whose data is on the RAM output.
   logic [CW-1:0]          rd_idx_ff, rd_idx_in;
   logic                   dv_ff, dv_in;
   logic [IW-1:0]          pidx_ff, pidx_in;
   logic [TOTAL_W-1:0]     val_ff, val_in;

   // Last candidate seen, for a walk that runs off the end.
   logic                   cand_ok_ff, cand_ok_in;
   logic [IW-1:0]          cand_idx_ff, cand_idx_in;
   logic [FIELD_W-1:0]     cand_tag_ff, cand_tag_in;
   logic [WS-1:0]          cand_wt_ff, cand_wt_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   // RAM port.
   logic                   ram_we;
   logic [IW-1:0]          ram_waddr;
   logic [RAM_W-1:0]       ram_wdata;
   logic                   ram_re;
   logic [RAM_W-1:0]       ram_q;
   logic [WS-1:0]          q_wt;
   logic [FIELD_W-1:0]     q_tag;

   // Decode.
   logic                   accept;
   logic                   is_cand;
   logic                   hit;
   logic                   all_last;
   logic                   exhausted;
   logic                   walk_end;
   logic                   start_walk;
   logic                   set_all;
   logic                   more_reads;
   logic                   stream_more;

   logic                   fin_ok;
   logic [IW-1:0]          fin_idx;
   logic [FIELD_W-1:0]     fin_tag;
   logic [WS-1:0]          fin_wt;

   wrep_ram #(
      .WIDTH (RAM_W),
      .DEPTH (ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (rd_idx_ff[IW-1:0]),
      .rd_data (ram_q)
   );

   assign q_wt  = ram_q[WS-1:0];
   assign q_tag = ram_q[WS +: FIELD_W];

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && (state_ff == ST_IDLE);
   assign set_all   = CMP_W'(req_data.pick_count) >= CMP_W'(count_ff);
   assign more_reads = (rd_idx_ff < count_ff);

   // Marked entries are skipped only while drawing without replacement.
   assign is_cand   = dv_ff && !((mode_ff == MODE_DRAW) && marks_ff[pidx_ff]);
   assign hit       = is_cand && (mode_ff != MODE_ALL) &&
                      (val_ff <= TOTAL_W'(q_wt));
   assign all_last  = dv_ff && (mode_ff == MODE_ALL) &&
                      ((CW'(pidx_ff) + CW'(1)) == count_ff);
   assign exhausted = !dv_ff && !more_reads && (mode_ff != MODE_ALL);
   assign walk_end  = (state_ff == ST_WALK) && (hit || all_last || exhausted);

   // A non-final result of a full-set stream; more of the stream follows.
   assign stream_more = rsp_valid && !rsp_data.last && (mode_ff == MODE_ALL);

   assign start_walk = accept && (
      ((req_data.kind == KIND_PICK) && (count_ff != '0)) ||
      ((req_data.kind == KIND_SET)  && (count_ff != '0) && set_all) ||
      ((req_data.kind == KIND_DRAW) && (draws_ff != '0)));

   // Chosen entry at the end of a weighted walk.
   assign fin_ok  = hit ? 1'b1  : cand_ok_ff;
   assign fin_idx = hit ? pidx_ff : cand_idx_ff;
   assign fin_tag = hit ? q_tag  : cand_tag_ff;
   assign fin_wt  = hit ? q_wt   : cand_wt_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start_walk) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (walk_end) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      mode_in      = mode_ff;
      count_in     = count_ff;
      total_in     = total_ff;
      remain_in    = remain_ff;
      draws_in     = draws_ff;
      marks_in     = marks_ff;
      rd_idx_in    = rd_idx_ff;
      dv_in        = 1'b0;
      pidx_in      = pidx_ff;
      val_in       = val_ff;
      cand_ok_in   = cand_ok_ff;
      cand_idx_in  = cand_idx_ff;
      cand_tag_in  = cand_tag_ff;
      cand_wt_in   = cand_wt_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ram_we       = 1'b0;
      ram_waddr    = count_ff[IW-1:0];
      ram_wdata    = {req_data.tag, req_data.weight[WS-1:0]};
      ram_re       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rd_idx_in  = '0;
               val_in     = req_data.random_value;
               cand_ok_in = 1'b0;
               case (req_data.kind)
                  KIND_CLEAR: begin
                     count_in  = '0;
                     total_in  = '0;
                     remain_in = '0;
                     draws_in  = '0;
                     marks_in  = '0;
                  end
                  KIND_APPEND: begin
                     if ((req_data.tag != '0) && (count_ff < CW'(ENTRIES))) begin
                        ram_we   = 1'b1;
                        marks_in[count_ff[IW-1:0]] = 1'b0;
                        count_in = count_ff + CW'(1);
                        total_in = total_ff + TOTAL_W'(req_data.weight[WS-1:0]);
                        draws_in = '0;
                     end
                  end
                  KIND_PICK: begin
                     mode_in = MODE_PICK;
                     if (count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = '{STATUS_EMPTY, '0, '0, 1'b1};
                     end
                  end
                  KIND_SET: begin
                     mode_in  = MODE_ALL;
                     draws_in = '0;
                     if (count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = '{STATUS_EMPTY, '0, '0, 1'b1};
                     end else if (!set_all && (req_data.pick_count != '0)) begin
                        marks_in  = '0;
                        remain_in = total_ff;
                        draws_in  = req_data.pick_count;
                     end
                  end
                  KIND_DRAW: begin
                     mode_in = MODE_DRAW;
                     if (draws_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = '{STATUS_NO_DRAW, '0, '0, 1'b1};
                     end
                  end
                  default: ;
               endcase
            end
         end

         ST_WALK: begin
            // Keep one read in flight ahead of the entry being checked.
            if (!walk_end && more_reads) begin
               ram_re    = 1'b1;
               rd_idx_in = rd_idx_ff + CW'(1);
               dv_in     = 1'b1;
               pidx_in   = rd_idx_ff[IW-1:0];
            end

            if (is_cand && (mode_ff != MODE_ALL) && !hit) begin
               cand_ok_in  = 1'b1;
               cand_idx_in = pidx_ff;
               cand_tag_in = q_tag;
               cand_wt_in  = q_wt;
               val_in      = val_ff - TOTAL_W'(q_wt);
            end

            if (dv_ff && (mode_ff == MODE_ALL)) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{STATUS_OK, ENTRY_INDEX_W'(pidx_ff), q_tag, all_last};
            end

            if (hit || exhausted) begin
               rsp_valid_in = 1'b1;
               if (!fin_ok) begin
                  // Every entry already drawn: the draw ends.
                  draws_in = '0;
                  rsp_in   = '{STATUS_EXHAUSTED, '0, '0, 1'b1};
               end else if (mode_ff == MODE_DRAW) begin
                  marks_in[fin_idx] = 1'b1;
                  remain_in = (remain_ff >= TOTAL_W'(fin_wt)) ?
                              (remain_ff - TOTAL_W'(fin_wt)) : '0;
                  draws_in  = draws_ff - PICK_COUNT_W'(1);
                  rsp_in    = '{STATUS_OK, ENTRY_INDEX_W'(fin_idx), fin_tag,
                                (draws_ff == PICK_COUNT_W'(1))};
               end else begin
                  rsp_in = '{STATUS_OK, ENTRY_INDEX_W'(fin_idx), fin_tag, 1'b1};
               end
            end
         end

         default: ;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         total_ff     <= '0;
         remain_ff    <= '0;
         draws_ff     <= '0;
         marks_ff     <= '0;
         dv_ff        <= 1'b0;
         rd_idx_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         remain_ff    <= remain_in;
         draws_ff     <= draws_in;
         marks_ff     <= marks_in;
         dv_ff        <= dv_in;
         rd_idx_ff    <= rd_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      pidx_ff     <= pidx_in;
      val_ff      <= val_in;
      cand_ok_ff  <= cand_ok_in;
      cand_idx_ff <= cand_idx_in;
      cand_tag_ff <= cand_tag_in;
      cand_wt_ff  <= cand_wt_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Checks.
   `WREP_ASSERT_NOW(a_no_read_when_idle, !busy, !dv_ff, "read data pending while idle")
   `WREP_ASSERT_NOW(a_draw_needs_entries, draws_ff != '0, count_ff != '0, "draw pending on empty table")
   `WREP_ASSERT_NOW(a_rd_idx_bound, busy, rd_idx_ff <= count_ff, "read index past entry count")
   `WREP_ASSERT_NOW(a_more_follow, stream_more, busy, "non-final result with walk stopped")
   `WREP_ASSERT_NEXT(a_walk_end_idle, walk_end, !busy, "walk end did not return to idle")

endmodule

// File: sim/weighted_random_entry_picker_tb.sv
// Testbench for weighted_random_entry_picker: directed and random items, checked
// against an in-bench model of the entry table. Depends on wrep_pkg and the block RTL.
`timescale 1ns / 1ps

module weighted_random_entry_picker_tb;
   import wrep_pkg::*;

   // Kinds the block does not decode; they must pass without a result.
   localparam logic [KIND_W-1:0]  KIND_SPARE_FIRST = 3'd5;
   localparam logic [KIND_W-1:0]  KIND_SPARE_LAST  = 3'd7;
   localparam logic [FIELD_W-1:0] TAG_NONE         = '0;
   localparam logic [TOTAL_W-1:0] VALUE_MAX        = '1;

   localparam int RANDOM_ITEMS  = 480;
   localparam int IDLE_PERCENT  = 21;
   // Items in this window are sent back to back, with no idle cycles.
   localparam int BURST_FIRST   = 200;
   localparam int BURST_LAST    = 300;
   localparam int DRAIN_CYCLES  = DEF_ENTRIES + 40;
   localparam int CYCLE_LIMIT   = 400000;

   // Model of the entry table; holds the results still owed by the block.
   class entry_pick_scoreboard;
      logic [FIELD_W-1:0] weights [DEF_ENTRIES];
      logic [FIELD_W-1:0] tags    [DEF_ENTRIES];
      bit                 marked  [DEF_ENTRIES];
      int unsigned        entry_count;
      logic [TOTAL_W-1:0] weight_total;
      logic [TOTAL_W-1:0] remaining_total;
      int unsigned        draws_left;
      rsp_type            expected_picks [$];
      int                 failures;

      function new();
         entry_count     = 0;
         weight_total    = '0;
         remaining_total = '0;
         draws_left      = 0;
         failures        = 0;
         foreach (marked[i]) marked[i] = 1'b0;
      endfunction

      function void owe_pick(status_type status, int idx, logic [FIELD_W-1:0] tag, bit last);
         rsp_type e;
         e.status      = status;
         e.entry_index = ENTRY_INDEX_W'(idx);
         e.entry_tag   = tag;
         e.last        = last;
         expected_picks = {expected_picks, e};
      endfunction

      // Roulette walk: subtract weights in table order until the value
      // reaches zero or below; falls back to the last candidate seen.
      function int walk_entries(logic [TOTAL_W-1:0] value, bit skip_marked);
         longint remain = longint'(value);
         int     chosen = -1;
         for (int i = 0; i < entry_count; i++) begin
            if (skip_marked && marked[i]) continue;
            chosen = i;
            remain -= longint'(weights[i]);
            if (remain <= 0) return i;
         end
         return chosen;
      endfunction

      function void note_item(req_type r);
         int pos;
         case (r.kind)
            KIND_CLEAR: begin
               entry_count     = 0;
               weight_total    = '0;
               remaining_total = '0;
               draws_left      = 0;
               foreach (marked[i]) marked[i] = 1'b0;
            end
            KIND_APPEND: begin
               if (r.tag != TAG_NONE && entry_count < DEF_ENTRIES) begin
                  weights[entry_count] = r.weight;
                  tags[entry_count]    = r.tag;
                  marked[entry_count]  = 1'b0;
                  entry_count++;
                  weight_total += TOTAL_W'(r.weight);
                  draws_left    = 0;
               end
            end
            KIND_PICK: begin
               if (entry_count == 0) begin
                  owe_pick(STATUS_EMPTY, 0, '0, 1'b1);
               end else begin
                  pos = walk_entries(r.random_value, 1'b0);
                  owe_pick(STATUS_OK, pos, tags[pos], 1'b1);
               end
            end
            KIND_SET: begin
               draws_left = 0;
               if (entry_count == 0) begin
                  owe_pick(STATUS_EMPTY, 0, '0, 1'b1);
               end else if (r.pick_count >= entry_count) begin
                  for (int i = 0; i < entry_count; i++)
                     owe_pick(STATUS_OK, i, tags[i], i + 1 == entry_count);
               end else if (r.pick_count != 0) begin
                  foreach (marked[i]) marked[i] = 1'b0;
                  remaining_total = weight_total;
                  draws_left      = r.pick_count;
               end
            end
            KIND_DRAW: begin
               if (draws_left == 0) begin
                  owe_pick(STATUS_NO_DRAW, 0, '0, 1'b1);
               end else begin
                  pos = walk_entries(r.random_value, 1'b1);
                  if (pos < 0) begin
                     draws_left = 0;
                     owe_pick(STATUS_EXHAUSTED, 0, '0, 1'b1);
                  end else begin
                     marked[pos]     = 1'b1;
                     remaining_total = (remaining_total >= weights[pos]) ?
                                       remaining_total - weights[pos] : '0;
                     draws_left--;
                     owe_pick(STATUS_OK, pos, tags[pos], draws_left == 0);
                  end
               end
            end
            default: ;
         endcase
      endfunction

      function void check_pick(rsp_type got);
         rsp_type e;
         if (expected_picks.size() == 0) begin
            $error("result with nothing owed: status %0d index %0d tag %0h last %0d",
                   got.status, got.entry_index, got.entry_tag, got.last);
            failures++;
            return;
         end
         e = expected_picks.pop_front();
         if (got.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, got.status);
            failures++;
         end
         if (got.entry_index !== e.entry_index) begin
            $error("entry_index: expected %0d, got %0d", e.entry_index, got.entry_index);
            failures++;
         end
         if (got.entry_tag !== e.entry_tag) begin
            $error("entry_tag: expected %0h, got %0h", e.entry_tag, got.entry_tag);
            failures++;
         end
         if (got.last !== e.last) begin
            $error("last: expected %0d, got %0d", e.last, got.last);
            failures++;
         end
      endfunction
   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    start     = 1'b0;
   logic    busy;
   req_type req_data  = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   entry_pick_scoreboard sb;
   int  useful_items = 0;   // items that change state or give a result
   int  cycle_count  = 0;
   bit  idle_enabled = 1'b1;

   weighted_random_entry_picker dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Watchdog: a hung block or a missing result ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Results are one-cycle strobes; sample at the edge that ends the cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_pick(rsp_data);
   end

   function automatic req_type item_of(logic [KIND_W-1:0] kind, logic [FIELD_W-1:0] weight,
                                       logic [FIELD_W-1:0] tag, logic [TOTAL_W-1:0] value,
                                       logic [PICK_COUNT_W-1:0] count);
      req_type r;
      r.kind         = kind;
      r.weight       = weight;
      r.tag          = tag;
      r.random_value = value;
      r.pick_count   = count;
      return r;
   endfunction

   // Mostly a legal value in 1..total; now and then zero, above total, or anything.
   function automatic logic [TOTAL_W-1:0] value_in(logic [TOTAL_W-1:0] total);
      case ($urandom_range(0, 19))
         0:       return '0;
         1:       return TOTAL_W'($urandom_range(32'(total) + 1, 32'(VALUE_MAX)));
         2:       return TOTAL_W'($urandom);
         default: return (total == 0) ? '0 : TOTAL_W'($urandom_range(1, 32'(total)));
      endcase
   endfunction

   // Present one item and hold it until the block takes it. Busy is read right
   // after the edge, so it is the value the block saw at that edge.
   task automatic send_item(req_type r);
      bit ignored;
      while (idle_enabled && $urandom_range(0, 99) < IDLE_PERCENT) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy !== 1'b0);
      ignored = r.kind > KIND_DRAW ||
                (r.kind == KIND_APPEND && (r.tag == TAG_NONE || sb.entry_count >= DEF_ENTRIES));
      if (!ignored) useful_items++;
      sb.note_item(r);
   endtask

   task automatic send_append();
      logic [FIELD_W-1:0] w;
      logic [FIELD_W-1:0] tag;
      case ($urandom_range(0, 9))
         0:       w = '0;
         1:       w = '1;
         2, 3:    w = FIELD_W'($urandom_range(1, 15));
         default: w = FIELD_W'($urandom);
      endcase
      tag = ($urandom_range(0, 29) == 0) ? TAG_NONE : FIELD_W'($urandom_range(1, 65535));
      send_item(item_of(KIND_APPEND, w, tag, TOTAL_W'($urandom),
                        PICK_COUNT_W'($urandom_range(0, 64))));
   endtask

   task automatic send_draw();
      send_item(item_of(KIND_DRAW, FIELD_W'($urandom), FIELD_W'($urandom),
                        value_in(sb.remaining_total), PICK_COUNT_W'($urandom_range(0, 64))));
   endtask

   // Begin a set draw, then step through it. Sometimes one draw too many, and
   // sometimes an append cuts the run short so the next draw finds none pending.
   task automatic run_set_draw();
      int  cnt;
      int  steps;
      int  cut_at;
      case ($urandom_range(0, 7))
         0:       cnt = 0;
         1:       cnt = $urandom_range(sb.entry_count, DEF_ENTRIES);
         default: cnt = $urandom_range(1, (sb.entry_count > 1) ? sb.entry_count - 1 : 1);
      endcase
      send_item(item_of(KIND_SET, FIELD_W'($urandom), FIELD_W'($urandom),
                        TOTAL_W'($urandom), PICK_COUNT_W'(cnt)));
      steps  = sb.draws_left + (($urandom_range(0, 7) == 0) ? 1 : 0);
      cut_at = ($urandom_range(0, 9) == 0 && steps > 1) ? $urandom_range(1, steps - 1) : -1;
      for (int k = 0; k < steps; k++) begin
         if (k == cut_at) send_append();
         send_draw();
      end
   endtask

   // Noise: undecoded kinds with random fields, or a draw with nothing pending.
   task automatic send_noise();
      req_type r;
      r = req_type'({$urandom, $urandom});
      if ($urandom_range(0, 3) == 0) r.kind = KIND_DRAW;
      else r.kind = KIND_W'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
      r.pick_count = PICK_COUNT_W'($urandom_range(0, 64));
      send_item(r);
   endtask

   // One random session: maybe clear, grow the table, then picks and draws.
   task automatic run_session();
      int n_add;
      if ($urandom_range(0, 99) < ((sb.entry_count > 40) ? 60 : 25))
         send_item(item_of(KIND_CLEAR, FIELD_W'($urandom), FIELD_W'($urandom),
                           TOTAL_W'($urandom), PICK_COUNT_W'($urandom_range(0, 64))));
      case ($urandom_range(0, 19))
         0:       n_add = DEF_ENTRIES - sb.entry_count + $urandom_range(1, 3);  // overfill
         1, 2:    n_add = $urandom_range(11, 30);
         default: n_add = $urandom_range(0, 8);
      endcase
      repeat (n_add) send_append();
      repeat ($urandom_range(1, 6)) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: send_item(item_of(KIND_PICK, FIELD_W'($urandom), FIELD_W'($urandom),
                                          value_in(sb.weight_total),
                                          PICK_COUNT_W'($urandom_range(0, 64))));
            4, 5, 6, 7: run_set_draw();
            default:    send_noise();
         endcase
      end
   endtask

   initial begin
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty-table cases first.
      send_item(item_of(KIND_CLEAR, '0, '0, '0, '0));
      send_item(item_of(KIND_PICK, '0, '0, 22'd5, '0));
      send_item(item_of(KIND_SET, '0, '0, '0, 7'd3));
      send_item(item_of(KIND_DRAW, '0, '0, 22'd1, '0));
      send_item(item_of(KIND_APPEND, 16'd5, TAG_NONE, '0, '0));
      // Zero weight, full-scale weight, then two ordinary entries.
      send_item(item_of(KIND_APPEND, '0, 16'h0001, '0, '0));
      send_item(item_of(KIND_APPEND, '1, '1, '0, '0));
      send_item(item_of(KIND_APPEND, 16'd1, 16'h5A5A, '0, '0));
      send_item(item_of(KIND_APPEND, 16'd300, 16'hA5A5, '0, '0));
      // Value zero, value past the total, smallest and exact-total values.
      send_item(item_of(KIND_PICK, '0, '0, '0, '0));
      send_item(item_of(KIND_PICK, '0, '0, VALUE_MAX, '0));
      send_item(item_of(KIND_PICK, '0, '0, 22'd1, '0));
      send_item(item_of(KIND_PICK, '0, '0, sb.weight_total, '0));
      // Set draws: count zero, count equal to the table, a count of 64, above the table.
      send_item(item_of(KIND_SET, '0, '0, '0, '0));
      send_item(item_of(KIND_SET, '0, '0, '0, 7'd4));
      send_item(item_of(KIND_SET, '0, '0, '0, 7'd64));
      // A run of two, then one draw past its end.
      send_item(item_of(KIND_SET, '0, '0, '0, 7'd2));
      send_item(item_of(KIND_DRAW, '0, '0, 22'd1, '0));
      send_item(item_of(KIND_DRAW, '0, '0, sb.remaining_total, '0));
      send_item(item_of(KIND_DRAW, '0, '0, 22'd1, '0));
      // An append in the middle of a run cancels it.
      send_item(item_of(KIND_SET, '0, '0, '0, 7'd3));
      send_item(item_of(KIND_DRAW, '0, '0, '0, '0));
      send_item(item_of(KIND_APPEND, 16'd7, 16'h1234, '0, '0));
      send_item(item_of(KIND_DRAW, '0, '0, 22'd2, '0));
      // Undecoded kinds, every field bit high on the last one.
      send_item(item_of(KIND_SPARE_FIRST, '0, '0, '0, '0));
      send_item('1);

      useful_items = 0;
      while (useful_items < RANDOM_ITEMS) begin
         idle_enabled = !(useful_items >= BURST_FIRST && useful_items <= BURST_LAST);
         run_session();
      end
      start <= 1'b0;

      while (sb.expected_picks.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.failures == 0 && sb.expected_picks.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+sv
sv/wrep_pkg.sv
sv/wrep_ram.sv
sv/weighted_random_entry_picker.sv
sim/weighted_random_entry_picker_tb.sv
